/* sv/tptz_pkg.sv */
// ----------------------------------------------------------------------------
// tptz_pkg: shared types and constants of the compensator
// Microcode word layout, the control program, register indexes and reset
// values of the configuration registers.
// ----------------------------------------------------------------------------
package tptz_pkg;

  localparam int DAC_BITS_DEFAULT = 8;

  localparam int ADC_W   = 12;
  localparam int REF_W   = 21;
  localparam int COEF_W  = 16;
  localparam int VOLT_W  = 32;
  localparam int CFG_W   = 21;
  localparam int INDEX_W = 3;
  localparam int STEP_W  = 4;

  localparam logic [INDEX_W-1:0] REG_REFERENCE = 3'd0;
  localparam logic [INDEX_W-1:0] REG_SENSE     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_ZERO_NOW  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_ZERO_ONE  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_ZERO_TWO  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_POLE_ONE  = 3'd5;
  localparam logic [INDEX_W-1:0] REG_POLE_TWO  = 3'd6;
  localparam logic [INDEX_W-1:0] REG_DAC_GAIN  = 3'd7;

  localparam logic [REF_W-1:0]  RESET_REFERENCE = 21'd163840;
  localparam logic [COEF_W-1:0] RESET_SENSE     = 16'd20468;
  localparam logic [COEF_W-1:0] RESET_ZERO_NOW  = 16'd2127;
  localparam logic [COEF_W-1:0] RESET_ZERO_ONE  = 16'd251;
  localparam logic [COEF_W-1:0] RESET_ZERO_TWO  = 16'hF8B1;
  localparam logic [COEF_W-1:0] RESET_POLE_ONE  = 16'd25231;
  localparam logic [COEF_W-1:0] RESET_POLE_TWO  = 16'd7209;
  localparam logic [COEF_W-1:0] RESET_DAC_GAIN  = 16'd5000;

  typedef enum logic [2:0] {
    A_SENSE, A_P1, A_P2, A_Z0, A_Z1, A_Z2, A_DAC
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ADC, B_D1, B_D2, B_NT, B_MAG
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_ADC, WR_ERR, WR_NT, WR_CTL, WR_OUT
  } wr_t;

  typedef enum logic [1:0] {
    J_NEXT, J_HOLD_IN, J_LOOP_OUT
  } jmp_t;

  typedef struct packed {
    logic              mul_en;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc;
    wr_t               wr;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   go;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } stat_t;

  function automatic ucode_t make_uc(logic mul_en, a_sel_t a_sel, b_sel_t b_sel,
                                     acc_op_t acc, wr_t wr, jmp_t jmp);
    ucode_t w;
    w.mul_en = mul_en;
    w.a_sel  = a_sel;
    w.b_sel  = b_sel;
    w.acc    = acc;
    w.wr     = wr;
    w.jmp    = jmp;
    w.target = '0;
    return w;
  endfunction

  // The multiplier result is registered, so each product is consumed one
  // step after it is issued.
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      4'd0:    w = make_uc(1'b0, A_SENSE, B_ADC, ACC_HOLD, WR_ADC,  J_HOLD_IN);
      4'd1:    w = make_uc(1'b1, A_SENSE, B_ADC, ACC_HOLD, WR_NONE, J_NEXT);
      4'd2:    w = make_uc(1'b1, A_P1,    B_D1,  ACC_HOLD, WR_ERR,  J_NEXT);
      4'd3:    w = make_uc(1'b1, A_P2,    B_D2,  ACC_LOAD, WR_NONE, J_NEXT);
      4'd4:    w = make_uc(1'b0, A_P2,    B_D2,  ACC_ADD,  WR_NONE, J_NEXT);
      4'd5:    w = make_uc(1'b0, A_Z0,    B_NT,  ACC_HOLD, WR_NT,   J_NEXT);
      4'd6:    w = make_uc(1'b1, A_Z0,    B_NT,  ACC_HOLD, WR_NONE, J_NEXT);
      4'd7:    w = make_uc(1'b1, A_Z1,    B_D1,  ACC_LOAD, WR_NONE, J_NEXT);
      4'd8:    w = make_uc(1'b1, A_Z2,    B_D2,  ACC_ADD,  WR_NONE, J_NEXT);
      4'd9:    w = make_uc(1'b0, A_Z2,    B_D2,  ACC_ADD,  WR_NONE, J_NEXT);
      4'd10:   w = make_uc(1'b0, A_DAC,   B_MAG, ACC_HOLD, WR_CTL,  J_NEXT);
      4'd11:   w = make_uc(1'b1, A_DAC,   B_MAG, ACC_HOLD, WR_NONE, J_NEXT);
      4'd12:   w = make_uc(1'b0, A_DAC,   B_MAG, ACC_HOLD, WR_OUT,  J_LOOP_OUT);
      default: w = make_uc(1'b0, A_SENSE, B_ADC, ACC_HOLD, WR_NONE, J_LOOP_OUT);
    endcase
    return w;
  endfunction

endpackage

/* sv/two_pole_two_zero_compensator.sv */
// ----------------------------------------------------------------------------
// two_pole_two_zero_compensator: second-order voltage loop compensator
// Measures the output from a summed ADC word, forms the error against the
// reference, runs a direct form II two-pole two-zero filter and drives a
// saturated DAC code.
// ----------------------------------------------------------------------------
// Each input word is paced from acceptance to a result in the output
// register by the microcode program, which issues the seven products of
// one sample through a single shared 17 by 33 bit multiplier. The next
// word can be accepted in the cycle after the result is loaded into the
// output register, so a new word is taken only once the last result has
// reached that register. Configuration writes take effect at once and are
// meant to be made while no word is in flight.
module two_pole_two_zero_compensator #(
  parameter int DAC_BITS = tptz_pkg::DAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tptz_pkg::INDEX_W-1:0]       cfg_addr,
  input  logic [tptz_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: adc_sum[11:0], ignored padding.
  input  logic [15:0]                        s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Fields from bit 0: dac_code, dac_clipped, error_volts, control_volts,
  // zero padding.
  output logic [((DAC_BITS+65+7)/8)*8-1:0]   m_tdata
);

  localparam int OUT_W  = ((DAC_BITS + 65 + 7) / 8) * 8;
  localparam int VOLT_W = tptz_pkg::VOLT_W;

  logic [tptz_pkg::REF_W-1:0]  reference_volts;
  logic [tptz_pkg::COEF_W-1:0] sense_gain;
  logic [tptz_pkg::COEF_W-1:0] zero_coef_now;
  logic [tptz_pkg::COEF_W-1:0] zero_coef_one;
  logic [tptz_pkg::COEF_W-1:0] zero_coef_two;
  logic [tptz_pkg::COEF_W-1:0] pole_coef_one;
  logic [tptz_pkg::COEF_W-1:0] pole_coef_two;
  logic [tptz_pkg::COEF_W-1:0] dac_gain;

  tptz_pkg::ctrl_t          ctrl;
  tptz_pkg::stat_t          stat;
  logic [DAC_BITS-1:0]      dp_code;
  logic                     dp_clipped;
  logic signed [VOLT_W-1:0] dp_error;
  logic signed [VOLT_W-1:0] dp_control;
  logic                     commit;

  logic                     out_valid;
  logic [DAC_BITS-1:0]      out_code;
  logic                     out_clipped;
  logic [VOLT_W-1:0]        out_error;
  logic [VOLT_W-1:0]        out_control;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_volts <= tptz_pkg::RESET_REFERENCE;
      sense_gain      <= tptz_pkg::RESET_SENSE;
      zero_coef_now   <= tptz_pkg::RESET_ZERO_NOW;
      zero_coef_one   <= tptz_pkg::RESET_ZERO_ONE;
      zero_coef_two   <= tptz_pkg::RESET_ZERO_TWO;
      pole_coef_one   <= tptz_pkg::RESET_POLE_ONE;
      pole_coef_two   <= tptz_pkg::RESET_POLE_TWO;
      dac_gain        <= tptz_pkg::RESET_DAC_GAIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        tptz_pkg::REG_REFERENCE: reference_volts <= cfg_data;
        tptz_pkg::REG_SENSE:     sense_gain      <= cfg_data[15:0];
        tptz_pkg::REG_ZERO_NOW:  zero_coef_now   <= cfg_data[15:0];
        tptz_pkg::REG_ZERO_ONE:  zero_coef_one   <= cfg_data[15:0];
        tptz_pkg::REG_ZERO_TWO:  zero_coef_two   <= cfg_data[15:0];
        tptz_pkg::REG_POLE_ONE:  pole_coef_one   <= cfg_data[15:0];
        tptz_pkg::REG_POLE_TWO:  pole_coef_two   <= cfg_data[15:0];
        tptz_pkg::REG_DAC_GAIN:  dac_gain        <= cfg_data[15:0];
        default:                 ;
      endcase
    end
  end

  assign s_tready      = (ctrl.uc.jmp == tptz_pkg::J_HOLD_IN);
  assign stat.in_fire  = s_tvalid && s_tready;
  assign stat.out_free = !out_valid || m_tready;
  assign commit        = ctrl.go && (ctrl.uc.wr == tptz_pkg::WR_OUT);

  tptz_sequencer u_sequencer (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  tptz_datapath #(
    .DAC_BITS (DAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .adc_sum         (s_tdata[11:0]),
    .reference_volts (reference_volts),
    .sense_gain      (sense_gain),
    .zero_coef_now   (zero_coef_now),
    .zero_coef_one   (zero_coef_one),
    .zero_coef_two   (zero_coef_two),
    .pole_coef_one   (pole_coef_one),
    .pole_coef_two   (pole_coef_two),
    .dac_gain        (dac_gain),
    .dac_code        (dp_code),
    .dac_clipped     (dp_clipped),
    .error_volts     (dp_error),
    .control_volts   (dp_control)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_code    <= dp_code;
      out_clipped <= dp_clipped;
      out_error   <= dp_error;
      out_control <= dp_control;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_control, out_error, out_clipped, out_code});

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    stat.in_fire |=> !s_tready)
    else $error("Input accepted while a word was still in flight.");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("Finished result did not reach the output register.");

  a_clip_full_scale: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_clipped) |-> (out_code == {DAC_BITS{1'b1}}))
    else $error("Clipped DAC code is not at full scale.");
`endif

endmodule

/* sv/tptz_sequencer.sv */
// ----------------------------------------------------------------------------
// tptz_sequencer: step counter and control store
// Reads one control word per step and resolves the conditional jumps.
// ----------------------------------------------------------------------------
module tptz_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  tptz_pkg::stat_t  stat,
  output tptz_pkg::ctrl_t  ctrl
);

  logic [tptz_pkg::STEP_W-1:0] step;
  logic [tptz_pkg::STEP_W-1:0] step_next;
  tptz_pkg::ucode_t            word;
  logic                        go;

  assign word = tptz_pkg::ucode_rom(step);

  always_comb begin
    case (word.jmp)
      tptz_pkg::J_HOLD_IN: begin
        go        = stat.in_fire;
        step_next = go ? step + 1'b1 : step;
      end
      tptz_pkg::J_LOOP_OUT: begin
        go        = stat.out_free;
        step_next = go ? word.target : step;
      end
      default: begin
        go        = 1'b1;
        step_next = step + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.uc = word;
  assign ctrl.go = go;

endmodule

/* sv/tptz_datapath.sv */
// ----------------------------------------------------------------------------
// tptz_datapath: shared multiplier, accumulator and loop registers
// Executes the control words: at most one signed product per step,
// accumulation, saturation to 32 bits and the DAC scaling.
// ----------------------------------------------------------------------------
module tptz_datapath #(
  parameter int DAC_BITS = tptz_pkg::DAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tptz_pkg::ctrl_t                     ctrl,
  input  logic [tptz_pkg::ADC_W-1:0]          adc_sum,
  input  logic [tptz_pkg::REF_W-1:0]          reference_volts,
  input  logic [tptz_pkg::COEF_W-1:0]         sense_gain,
  input  logic [tptz_pkg::COEF_W-1:0]         zero_coef_now,
  input  logic [tptz_pkg::COEF_W-1:0]         zero_coef_one,
  input  logic [tptz_pkg::COEF_W-1:0]         zero_coef_two,
  input  logic [tptz_pkg::COEF_W-1:0]         pole_coef_one,
  input  logic [tptz_pkg::COEF_W-1:0]         pole_coef_two,
  input  logic [tptz_pkg::COEF_W-1:0]         dac_gain,
  output logic [DAC_BITS-1:0]                 dac_code,
  output logic                                dac_clipped,
  output logic signed [tptz_pkg::VOLT_W-1:0]  error_volts,
  output logic signed [tptz_pkg::VOLT_W-1:0]  control_volts
);

  localparam int A_W    = tptz_pkg::COEF_W + 1;
  localparam int B_W    = tptz_pkg::VOLT_W + 1;
  localparam int P_W    = A_W + B_W;
  localparam int ACC_W  = P_W + 2;
  localparam int RAW_W  = P_W - 24;
  localparam int VOLT_W = tptz_pkg::VOLT_W;

  function automatic logic [VOLT_W-1:0] sat32(logic [ACC_W-1:0] v);
    if ((&v[ACC_W-1:VOLT_W-1]) || !(|v[ACC_W-1:VOLT_W-1])) begin
      return v[VOLT_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(VOLT_W-1){1'b0}}} : {1'b0, {(VOLT_W-1){1'b1}}};
  endfunction

  logic [tptz_pkg::ADC_W-1:0] adc;
  logic signed [VOLT_W-1:0]   err;
  logic signed [VOLT_W-1:0]   nt;
  logic signed [VOLT_W-1:0]   ctl;
  logic signed [VOLT_W-1:0]   delay_one;
  logic signed [VOLT_W-1:0]   delay_two;
  logic signed [A_W-1:0]      mul_a;
  logic signed [B_W-1:0]      mul_b;
  logic signed [P_W-1:0]      prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc_sh;
  logic signed [ACC_W-1:0]    nt_sum;
  logic [B_W-1:0]             mag;
  logic [RAW_W-1:0]           raw;
  logic [VOLT_W-1:0]          measured;

  assign mag = ctl[VOLT_W-1] ? (B_W'(0) - {ctl[VOLT_W-1], ctl}) : {1'b0, ctl};

  always_comb begin
    case (ctrl.uc.a_sel)
      tptz_pkg::A_SENSE: mul_a = $signed({1'b0, sense_gain});
      tptz_pkg::A_P1:    mul_a = $signed({pole_coef_one[15], pole_coef_one});
      tptz_pkg::A_P2:    mul_a = $signed({pole_coef_two[15], pole_coef_two});
      tptz_pkg::A_Z0:    mul_a = $signed({zero_coef_now[15], zero_coef_now});
      tptz_pkg::A_Z1:    mul_a = $signed({zero_coef_one[15], zero_coef_one});
      tptz_pkg::A_Z2:    mul_a = $signed({zero_coef_two[15], zero_coef_two});
      tptz_pkg::A_DAC:   mul_a = $signed({1'b0, dac_gain});
      default:           mul_a = '0;
    endcase
    case (ctrl.uc.b_sel)
      tptz_pkg::B_ADC: mul_b = $signed({{(B_W-tptz_pkg::ADC_W){1'b0}}, adc});
      tptz_pkg::B_D1:  mul_b = $signed({delay_one[VOLT_W-1], delay_one});
      tptz_pkg::B_D2:  mul_b = $signed({delay_two[VOLT_W-1], delay_two});
      tptz_pkg::B_NT:  mul_b = $signed({nt[VOLT_W-1], nt});
      tptz_pkg::B_MAG: mul_b = $signed(mag);
      default:         mul_b = '0;
    endcase
  end

  assign prod_ext = {{(ACC_W-P_W){prod[P_W-1]}}, prod};
  assign acc_sh   = acc >>> 15;
  assign nt_sum   = {{(ACC_W-VOLT_W){err[VOLT_W-1]}}, err} + acc_sh;
  assign measured = {{(VOLT_W-20){1'b0}}, prod[27:8]};

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.uc.mul_en) begin
      prod <= P_W'(mul_a) * P_W'(mul_b);
    end
    if (ctrl.go) begin
      case (ctrl.uc.acc)
        tptz_pkg::ACC_LOAD: acc <= prod_ext;
        tptz_pkg::ACC_ADD:  acc <= acc + prod_ext;
        default:            acc <= acc;
      endcase
      case (ctrl.uc.wr)
        tptz_pkg::WR_ADC: adc <= adc_sum;
        tptz_pkg::WR_ERR: err <= $signed({{(VOLT_W-tptz_pkg::REF_W){1'b0}}, reference_volts}
                                         - measured);
        tptz_pkg::WR_NT:  nt  <= $signed(sat32(nt_sum));
        tptz_pkg::WR_CTL: ctl <= $signed(sat32(acc_sh));
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (ctrl.go && ctrl.uc.wr == tptz_pkg::WR_OUT) begin
      delay_two <= delay_one;
      delay_one <= nt;
    end
  end

  assign raw           = prod[P_W-1:24];
  assign dac_clipped   = |raw[RAW_W-1:DAC_BITS];
  assign dac_code      = dac_clipped ? {DAC_BITS{1'b1}} : raw[DAC_BITS-1:0];
  assign error_volts   = err;
  assign control_volts = ctl;

endmodule

/* test/tb_two_pole_two_zero_compensator.sv */
// ----------------------------------------------------------------------------
// tb_two_pole_two_zero_compensator: self-checking bench for the compensator
// A directed table covers the reset state, the extremes of the fields and
// registers, saturation of the delay terms and of the DAC code, and negative
// control. Random phases follow under fresh register settings. Untyped
// words are predicted by a fixed-point model in the bench, while both stream
// sides idle at random and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_two_pole_two_zero_compensator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_W = tptz_pkg::INDEX_W;
  localparam int CFG_W = tptz_pkg::CFG_W;
  localparam int REF_W = tptz_pkg::REF_W;
  localparam int COEF_W = tptz_pkg::COEF_W;
  localparam int ADC_W = tptz_pkg::ADC_W;
  localparam int DAC_BITS = 8;
  localparam int OUT_W = ((DAC_BITS + 65 + 7) / 8) * 8;
  localparam longint CODE_FULL = (64'sd1 << DAC_BITS) - 1;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 150;

  typedef struct {
    logic [DAC_BITS-1:0] code;
    logic                clipped;
    logic signed [31:0]  err_v;
    logic signed [31:0]  ctl_v;
  } dac_result_t;

  typedef enum {ROW_WRITE, ROW_WORD, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [INDEX_W-1:0] addr;
    logic [CFG_W-1:0]   data;
    logic [15:0]        word;
    dac_result_t        typed;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [INDEX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;

  // Shadow of the register file and of the filter history.
  logic [REF_W-1:0]         ref_v = tptz_pkg::RESET_REFERENCE;
  logic [COEF_W-1:0]        sense_g = tptz_pkg::RESET_SENSE;
  logic signed [COEF_W-1:0] zero_now = tptz_pkg::RESET_ZERO_NOW;
  logic signed [COEF_W-1:0] zero_one = tptz_pkg::RESET_ZERO_ONE;
  logic signed [COEF_W-1:0] zero_two = tptz_pkg::RESET_ZERO_TWO;
  logic signed [COEF_W-1:0] pole_one = tptz_pkg::RESET_POLE_ONE;
  logic signed [COEF_W-1:0] pole_two = tptz_pkg::RESET_POLE_TWO;
  logic [COEF_W-1:0]        dac_g = tptz_pkg::RESET_DAC_GAIN;
  logic signed [31:0]       hist_one = '0;
  logic signed [31:0]       hist_two = '0;

  dac_result_t dac_words_due[$];
  plan_row_t   plan[$];

  bit steady = 1'b0;
  int failures = 0;
  int words_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int clipped_seen = 0;
  int negative_seen = 0;

  two_pole_two_zero_compensator #(.DAC_BITS(DAC_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic dac_result_t compensate(input logic [ADC_W-1:0] adc);
    dac_result_t res;
    longint sensed, err, fb, nt, num, ctl, mag, raw;
    sensed = (longint'(adc) * longint'(sense_g)) >>> 8;
    err = longint'(ref_v) - sensed;
    fb = longint'(pole_one) * longint'(hist_one) + longint'(pole_two) * longint'(hist_two);
    nt = clamp32(err + (fb >>> 15));
    num = longint'(zero_now) * nt + longint'(zero_one) * longint'(hist_one)
        + longint'(zero_two) * longint'(hist_two);
    ctl = clamp32(num >>> 15);
    mag = (ctl < 0) ? -ctl : ctl;
    raw = (mag * longint'(dac_g)) >>> 24;
    res.clipped = (raw > CODE_FULL);
    res.code = res.clipped ? CODE_FULL[DAC_BITS-1:0] : raw[DAC_BITS-1:0];
    res.err_v = err[31:0];
    res.ctl_v = ctl[31:0];
    hist_two = hist_one;
    hist_one = nt[31:0];
    return res;
  endfunction

  function automatic void mirror_reg(input logic [INDEX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
    case (idx)
      tptz_pkg::REG_REFERENCE: ref_v = data[REF_W-1:0];
      tptz_pkg::REG_SENSE:     sense_g = data[COEF_W-1:0];
      tptz_pkg::REG_ZERO_NOW:  zero_now = data[COEF_W-1:0];
      tptz_pkg::REG_ZERO_ONE:  zero_one = data[COEF_W-1:0];
      tptz_pkg::REG_ZERO_TWO:  zero_two = data[COEF_W-1:0];
      tptz_pkg::REG_POLE_ONE:  pole_one = data[COEF_W-1:0];
      tptz_pkg::REG_POLE_TWO:  pole_two = data[COEF_W-1:0];
      tptz_pkg::REG_DAC_GAIN:  dac_g = data[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_setting(input logic [INDEX_W-1:0] idx,
                                                    input bit nominal);
    int r;
    logic [COEF_W-1:0] v;
    logic [CFG_W-COEF_W-1:0] upper;
    r = nominal ? 2 : $urandom_range(0, 9);
    upper = (!nominal && $urandom_range(0, 3) == 0) ? (CFG_W - COEF_W)'($urandom) : '0;
    if (idx == tptz_pkg::REG_REFERENCE) begin
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return tptz_pkg::RESET_REFERENCE;
      return CFG_W'($urandom);
    end
    v = COEF_W'($urandom);
    if (r == 2) begin
      case (idx)
        tptz_pkg::REG_SENSE:    v = tptz_pkg::RESET_SENSE;
        tptz_pkg::REG_ZERO_NOW: v = tptz_pkg::RESET_ZERO_NOW;
        tptz_pkg::REG_ZERO_ONE: v = tptz_pkg::RESET_ZERO_ONE;
        tptz_pkg::REG_ZERO_TWO: v = tptz_pkg::RESET_ZERO_TWO;
        tptz_pkg::REG_POLE_ONE: v = tptz_pkg::RESET_POLE_ONE;
        tptz_pkg::REG_POLE_TWO: v = tptz_pkg::RESET_POLE_TWO;
        default:                v = tptz_pkg::RESET_DAC_GAIN;
      endcase
    end else if (idx == tptz_pkg::REG_SENSE || idx == tptz_pkg::REG_DAC_GAIN) begin
      if (r == 0) v = '0;
      else if (r == 1) v = '1;
    end else begin
      if (r == 0) v = 16'h8000;
      else if (r == 1) v = 16'h7FFF;
      else if (r < 6) v = COEF_W'($urandom_range(0, 16383) - 8192);
    end
    return {upper, v};
  endfunction

  // Most words sit near the level the loop regulates to, the rest anywhere.
  function automatic logic [15:0] pick_adc();
    int r, center, v;
    logic [3:0] pad;
    r = $urandom_range(0, 99);
    pad = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd0;
    if (sense_g != 0) center = (int'(ref_v) * 256) / int'(sense_g);
    else center = 2048;
    if (r < 75) v = center + int'($urandom_range(0, 64)) - 32;
    else if (r < 92) v = $urandom_range(0, 4095);
    else v = (r < 95) ? 0 : (r < 98) ? 4092 : 4095;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return {pad, v[11:0]};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic plan_row_t reg_row(input logic [INDEX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, addr: idx, data: data, word: '0, typed: '{default: '0}};
    return row;
  endfunction

  function automatic plan_row_t word_row(input logic [15:0] word);
    plan_row_t row;
    row = '{kind: ROW_WORD, addr: '0, data: '0, word: word, typed: '{default: '0}};
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [15:0] word, input int code,
                                          input bit clip, input int err_v, input int ctl_v);
    plan_row_t row;
    row = '{kind: ROW_KNOWN, addr: '0, data: '0, word: word, typed: '{default: '0}};
    row.typed.code = code[DAC_BITS-1:0];
    row.typed.clipped = clip;
    row.typed.err_v = err_v;
    row.typed.ctl_v = ctl_v;
    return row;
  endfunction

  task automatic mismatch(input string what, input longint want, input longint got);
    failures++;
    if (failures <= 10)
      $display("MISMATCH %s at word %0d: expected %0d, got %0d",
               what, results_seen, want, got);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    mirror_reg(idx, data);
    reg_writes++;
  endtask

  task automatic send_word(input logic [15:0] word, input bit known,
                           input dac_result_t typed);
    dac_result_t want;
    int gap;
    gap = pick_gap();
    cfg_we <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    want = compensate(word[ADC_W-1:0]);
    dac_words_due.push_back(known ? typed : want);
    words_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (dac_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic take_result();
    dac_result_t got, want;
    got.code = m_tdata[DAC_BITS-1:0];
    got.clipped = m_tdata[DAC_BITS];
    got.err_v = m_tdata[DAC_BITS+32:DAC_BITS+1];
    got.ctl_v = m_tdata[DAC_BITS+64:DAC_BITS+33];
    results_seen++;
    if (dac_words_due.size() == 0) begin
      mismatch("unexpected word, control_volts", 0, got.ctl_v);
      return;
    end
    want = dac_words_due.pop_front();
    if (want.clipped) clipped_seen++;
    if (want.ctl_v < 0) negative_seen++;
    if (got.code !== want.code) mismatch("dac_code", want.code, got.code);
    if (got.clipped !== want.clipped) mismatch("dac_clipped", want.clipped, got.clipped);
    if (got.err_v !== want.err_v) mismatch("error_volts", want.err_v, got.err_v);
    if (got.ctl_v !== want.ctl_v) mismatch("control_volts", want.ctl_v, got.ctl_v);
  endtask

  initial begin : sink
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) take_result();
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [INDEX_W-1:0] idx;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset state: zero delays, 2.5 V reference, nothing measured.
    plan.push_back(known_row(16'd0, 3, 1'b0, 163840, 10635));
    plan.push_back(word_row(16'hF_FFF));
    plan.push_back(word_row(16'd4092));
    plan.push_back(word_row(16'd2048));
    // Zero numerator: control is zero whatever the history holds.
    plan.push_back(reg_row(tptz_pkg::REG_ZERO_NOW, '0));
    plan.push_back(reg_row(tptz_pkg::REG_ZERO_ONE, '0));
    plan.push_back(reg_row(tptz_pkg::REG_ZERO_TWO, '0));
    plan.push_back(reg_row(tptz_pkg::REG_REFERENCE, '1));
    plan.push_back(reg_row(tptz_pkg::REG_SENSE, '0));
    plan.push_back(known_row(16'd4095, 0, 1'b0, 2097151, 0));
    plan.push_back(reg_row(tptz_pkg::REG_SENSE, 21'h00FFFF));
    plan.push_back(reg_row(tptz_pkg::REG_REFERENCE, '0));
    plan.push_back(known_row(16'd4095, 0, 1'b0, -1048304, 0));
    // Full-scale gains drive the delay terms and the control into saturation.
    plan.push_back(reg_row(tptz_pkg::REG_POLE_ONE, 21'h007FFF));
    plan.push_back(reg_row(tptz_pkg::REG_POLE_TWO, 21'h007FFF));
    plan.push_back(reg_row(tptz_pkg::REG_ZERO_NOW, 21'h007FFF));
    plan.push_back(reg_row(tptz_pkg::REG_ZERO_ONE, 21'h007FFF));
    plan.push_back(reg_row(tptz_pkg::REG_ZERO_TWO, 21'h1F8000));
    plan.push_back(reg_row(tptz_pkg::REG_DAC_GAIN, 21'h1FFFFF));
    plan.push_back(reg_row(tptz_pkg::REG_REFERENCE, '1));
    plan.push_back(reg_row(tptz_pkg::REG_SENSE, '0));
    repeat (14) plan.push_back(word_row(16'd0));
    // Inverted feedback flips the history to the negative rail.
    plan.push_back(reg_row(tptz_pkg::REG_POLE_ONE, 21'h008000));
    plan.push_back(reg_row(tptz_pkg::REG_POLE_TWO, 21'h008000));
    plan.push_back(reg_row(tptz_pkg::REG_REFERENCE, '0));
    plan.push_back(reg_row(tptz_pkg::REG_SENSE, 21'h00FFFF));
    repeat (4) plan.push_back(word_row(16'd4095));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        send_word(plan[i].word, plan[i].kind == ROW_KNOWN, plan[i].typed);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      steady = (p % 3 == 1);
      for (int r = 0; r < 8; r++) begin
        idx = r[INDEX_W-1:0];
        write_reg(idx, pick_setting(idx, p == 0));
      end
      repeat (PHASE_WORDS) send_word(pick_adc(), 1'b0, '{default: '0});
    end

    wait_idle();
    steady = 1'b0;
    repeat (20) @(posedge clk);
    $display("Sent %0d words through %0d settings with %0d register writes.",
             words_sent, PHASES + 5, reg_writes);
    $display("Checked %0d results: %0d saturated codes, %0d with negative control.",
             results_seen, clipped_seen, negative_seen);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("Mismatches: %0d", failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results still due.", dac_words_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* two_pole_two_zero_compensator.f */
sv/tptz_pkg.sv
sv/tptz_sequencer.sv
sv/tptz_datapath.sv
sv/two_pole_two_zero_compensator.sv
test/tb_two_pole_two_zero_compensator.sv
